// ----- sv/tbpi_pkg.sv -----
// ============================================================================
// tbpi_pkg - shared definitions for the two-pole band-pass IIR
// Widths, register indexes, reset values and the control structures used
// between the sequencer and the digit-serial multiplier.
// ============================================================================
`default_nettype none

package tbpi_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // Fixed field widths.
    localparam int COEF_BITS  = 24;
    localparam int GAIN_BITS  = 16;
    localparam int STATE_BITS = 32;
    localparam int STATE_FRAC = 8;
    // The gain product is scaled down by the state fraction plus the gain fraction.
    localparam int OUT_SHIFT  = STATE_FRAC + 8;
    // The feed-forward sum is clamped to plus or minus two to this power.
    localparam int FF_LIMIT_LOG2 = 54;

    // Digit size of the serial multiplier operand.
    localparam int DIGIT = 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = COEF_BITS;

    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A0     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A1     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A2     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B1     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B2     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = 3'd5;

    // Reset values: a0 is unity in Q3.20, gain is unity in Q8.8.
    localparam logic signed [COEF_BITS-1:0] COEF_A0_RST = 24'sd1048576;
    localparam logic [GAIN_BITS-1:0]        GAIN_RST    = 16'd256;

    // Sequencer to multiplier.
    typedef struct packed {
        logic start;    // load operands and begin a product
        logic long_op;  // serial operand is a state word (more digits)
    } t_mul_cmd;

    // Multiplier to sequencer.
    typedef struct packed {
        logic busy;     // digits still being consumed
        logic done;     // one-cycle pulse, product is valid
    } t_mul_sts;

endpackage

`default_nettype wire

// ----- sv/two_pole_bandpass_iir.sv -----
// ============================================================================
// two_pole_bandpass_iir - two-pole band-pass resonator, one sample at a time
// Fixed-point biquad-style recursion with output gain, built around one
// shared digit-serial multiplier.
// ============================================================================
// Each accepted sample computes y = a0*x + a1*x1 + a2*x2 + b1*y1 + b2*y2 with
// Q3.20 coefficients, the feedback words holding y with 8 extra fraction bits,
// and returns y times the Q8.8 output gain, truncated toward zero and
// saturated to the sample width. The six products run one after another
// through the single 24 x 8 digit multiplier: each has a setup step, then
// takes its sample or state operand one 8-bit digit at a time, most
// significant digit first, and ends with an accumulation step, and the
// divide, clamp and saturation steps come on top of the products.
// One sample is in flight at a time; the input is ready again as soon as the
// result sits in the output register, even if the downstream side has not yet
// taken that transaction, so the next sample can be accepted while the
// previous result still waits in the output register to be taken.
// Setting tuser on an input transaction clears the delay line before that
// sample is used. Coefficients are written through the configuration channel
// while the filter is idle; indexes 0 to 4 hold a0, a1, a2, b1, b2 (24-bit
// signed), index 5 the 16-bit gain, other indexes are ignored.
// ============================================================================
`default_nettype none

module two_pole_bandpass_iir #(
    parameter int SAMPLE_BITS    = tbpi_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tbpi_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    // Configuration write channel.
    input  wire                                       i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire  [tbpi_pkg::CFG_INDEX_W-1:0]          i_cfg_index,
    input  wire  [tbpi_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    // Input samples.
    input  wire                                       i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]          i_s_axis_tdata, // sample_in, pad
    input  wire  [0:0]                                i_s_axis_tuser, // buffer_start
    // Output samples.
    output logic                                      o_m_axis_tvalid,
    input  wire                                       i_m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]          o_m_axis_tdata  // sample_out, pad
);

    localparam int SB         = SAMPLE_BITS;
    localparam int TD_W       = ((SB + 7) / 8) * 8;
    localparam int COEF_BITS  = tbpi_pkg::COEF_BITS;
    localparam int GAIN_BITS  = tbpi_pkg::GAIN_BITS;
    localparam int STATE_BITS = tbpi_pkg::STATE_BITS;
    localparam int DIGIT      = tbpi_pkg::DIGIT;

    // Multiplier operand shapes. The parallel side holds a coefficient or the
    // zero-extended gain; the serial side a sample or a state word.
    localparam int PAR_W    = (COEF_BITS > GAIN_BITS + 1) ? COEF_BITS : GAIN_BITS + 1;
    localparam int N_SHORT  = (SB + DIGIT - 1) / DIGIT;
    localparam int N_STATE  = (STATE_BITS + DIGIT - 1) / DIGIT;
    localparam int N_LONG   = (N_STATE > N_SHORT) ? N_STATE : N_SHORT;
    localparam int SER_W    = N_LONG * DIGIT;
    localparam int PROD_W   = PAR_W + SER_W;
    localparam int X_ALIGN  = SER_W - N_SHORT * DIGIT;

    // Accumulator: wide enough for the unclamped feed-forward sum, and for the
    // clamped sum scaled by the state fraction plus both feedback products.
    localparam int FF_W     = COEF_BITS + SB + 2;
    localparam int ACC_W    = ((FF_W > 56) ? FF_W : 56) + 10;

    localparam logic signed [ACC_W-1:0] FF_POS =
        ACC_W'(longint'(1) <<< tbpi_pkg::FF_LIMIT_LOG2);
    localparam logic signed [ACC_W-1:0] FF_NEG = -FF_POS;
    localparam logic signed [ACC_W-1:0] Y_MAX =
        ACC_W'((longint'(1) <<< (STATE_BITS - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] O_MAX =
        ACC_W'((longint'(1) <<< (SB - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] O_MIN = -O_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] BIAS_Y =
        ACC_W'((longint'(1) <<< COEF_FRAC_BITS) - longint'(1));
    localparam logic signed [ACC_W-1:0] BIAS_O =
        ACC_W'((longint'(1) <<< tbpi_pkg::OUT_SHIFT) - longint'(1));

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_BIAS  = 3'd5;
    localparam logic [2:0] ST_YUPD  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // Product terms, in the order they are evaluated.
    localparam logic [2:0] TERM_A0   = 3'd0;
    localparam logic [2:0] TERM_A1   = 3'd1;
    localparam logic [2:0] TERM_A2   = 3'd2;
    localparam logic [2:0] TERM_B1   = 3'd3;
    localparam logic [2:0] TERM_B2   = 3'd4;
    localparam logic [2:0] TERM_GAIN = 3'd5;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [2:0]                    r_state, n_state;
    logic [2:0]                    r_term,  n_term;
    logic signed [ACC_W-1:0]       r_acc,   n_acc;
    logic                          r_out_valid, n_out_valid;
    logic signed [SB-1:0]          r_out_data;

    logic signed [COEF_BITS-1:0]   r_coef_a0, r_coef_a1, r_coef_a2;
    logic signed [COEF_BITS-1:0]   r_coef_b1, r_coef_b2;
    logic [GAIN_BITS-1:0]          r_gain;

    // Delay line: current sample, two past inputs, two past outputs.
    logic signed [SB-1:0]          r_x, r_x1, r_x2;
    logic signed [STATE_BITS-1:0]  r_y1, r_y2;

    // ------------------------------------------------------------------------
    // Wires
    // ------------------------------------------------------------------------
    logic                          w_in_accept;
    logic                          w_out_load;
    tbpi_pkg::t_mul_cmd            w_mul_cmd;
    tbpi_pkg::t_mul_sts            w_mul_sts;
    logic signed [PAR_W-1:0]       w_par;
    logic [SER_W-1:0]              w_ser;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [ACC_W-1:0]       w_bias;
    logic signed [ACC_W-1:0]       w_addend;
    logic signed [ACC_W-1:0]       w_sum;
    logic signed [ACC_W-1:0]       w_ff_clamped;
    logic signed [ACC_W-1:0]       w_y_shift;
    logic signed [ACC_W-1:0]       w_y_sat;
    logic signed [STATE_BITS-1:0]  w_y;
    logic signed [ACC_W-1:0]       w_o_shift;
    logic signed [ACC_W-1:0]       w_o_sat;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TD_W'($unsigned(r_out_data));

    // ------------------------------------------------------------------------
    // Configuration registers. Bits above a register's width are dropped.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a0 <= tbpi_pkg::COEF_A0_RST;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
            r_gain    <= tbpi_pkg::GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tbpi_pkg::REG_COEF_A0:     r_coef_a0 <= i_cfg_data[COEF_BITS-1:0];
                tbpi_pkg::REG_COEF_A1:     r_coef_a1 <= i_cfg_data[COEF_BITS-1:0];
                tbpi_pkg::REG_COEF_A2:     r_coef_a2 <= i_cfg_data[COEF_BITS-1:0];
                tbpi_pkg::REG_COEF_B1:     r_coef_b1 <= i_cfg_data[COEF_BITS-1:0];
                tbpi_pkg::REG_COEF_B2:     r_coef_b2 <= i_cfg_data[COEF_BITS-1:0];
                tbpi_pkg::REG_OUTPUT_GAIN: r_gain    <= i_cfg_data[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Multiplier operand selection. Samples are sign-extended to a whole
    // number of digits and moved to the top of the serial word, so that the
    // multiplier always starts from its most significant bits.
    // ------------------------------------------------------------------------
    always_comb begin
        w_par = '0;
        w_ser = '0;
        case (r_term)
            TERM_A0: begin
                w_par = PAR_W'(r_coef_a0);
                w_ser = SER_W'(r_x) << X_ALIGN;
            end
            TERM_A1: begin
                w_par = PAR_W'(r_coef_a1);
                w_ser = SER_W'(r_x1) << X_ALIGN;
            end
            TERM_A2: begin
                w_par = PAR_W'(r_coef_a2);
                w_ser = SER_W'(r_x2) << X_ALIGN;
            end
            TERM_B1: begin
                w_par = PAR_W'(r_coef_b1);
                w_ser = SER_W'(r_y1);
            end
            TERM_B2: begin
                w_par = PAR_W'(r_coef_b2);
                w_ser = SER_W'(r_y2);
            end
            TERM_GAIN: begin
                // The gain is unsigned, so it gets a zero sign bit.
                w_par = PAR_W'($signed({1'b0, r_gain}));
                w_ser = SER_W'(r_y1);
            end
            default: begin
            end
        endcase
    end

    assign w_mul_cmd.start   = (r_state == ST_START);
    assign w_mul_cmd.long_op = (r_term >= TERM_B1);

    tbpi_dsmul #(
        .PAR_W   (PAR_W),
        .DIGIT   (DIGIT),
        .N_SHORT (N_SHORT),
        .N_LONG  (N_LONG)
    ) u_dsmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mul_cmd),
        .i_par   (w_par),
        .i_ser   (w_ser),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    // ------------------------------------------------------------------------
    // Accumulator datapath. One adder serves both the product accumulation
    // and the rounding bias: a negative value gets 2^k - 1 added before the
    // arithmetic shift so that the shift truncates toward zero.
    // ------------------------------------------------------------------------
    assign w_bias   = r_acc[ACC_W-1] ? ((r_term == TERM_GAIN) ? BIAS_O : BIAS_Y) : '0;
    assign w_addend = (r_state == ST_BIAS) ? w_bias : ACC_W'(w_prod);
    assign w_sum    = r_acc + w_addend;

    assign w_ff_clamped = (r_acc > FF_POS) ? FF_POS :
                          (r_acc < FF_NEG) ? FF_NEG : r_acc;

    assign w_y_shift = r_acc >>> COEF_FRAC_BITS;
    assign w_y_sat   = (w_y_shift > Y_MAX) ? Y_MAX :
                       (w_y_shift < Y_MIN) ? Y_MIN : w_y_shift;
    assign w_y       = w_y_sat[STATE_BITS-1:0];

    assign w_o_shift = r_acc >>> tbpi_pkg::OUT_SHIFT;
    assign w_o_sat   = (w_o_shift > O_MAX) ? O_MAX :
                       (w_o_shift < O_MIN) ? O_MIN : w_o_shift;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        w_out_load  = 1'b0;

        // The output register empties whenever downstream takes the transaction.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_acc   = '0;
                    n_term  = TERM_A0;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (w_mul_sts.done) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_acc = w_sum;
                case (r_term)
                    TERM_A2:   n_state = ST_CLAMP;
                    TERM_B2:   n_state = ST_BIAS;
                    TERM_GAIN: n_state = ST_BIAS;
                    default: begin
                        n_term  = r_term + 3'd1;
                        n_state = ST_START;
                    end
                endcase
            end
            ST_CLAMP: begin
                // Feed-forward sum is complete: clamp it, then line it up
                // with the extra fraction bits of the feedback words.
                n_acc   = w_ff_clamped <<< tbpi_pkg::STATE_FRAC;
                n_term  = TERM_B1;
                n_state = ST_START;
            end
            ST_BIAS: begin
                n_acc   = w_sum;
                n_state = (r_term == TERM_GAIN) ? ST_OUT : ST_YUPD;
            end
            ST_YUPD: begin
                n_acc   = '0;
                n_term  = TERM_GAIN;
                n_state = ST_START;
            end
            ST_OUT: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_term      <= TERM_A0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (w_out_load) begin
            r_out_data <= w_o_sat[SB-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Delay line. A buffer start clears the history before the new sample is
    // used; the line advances once the new output word is known.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (w_in_accept) begin
            r_x <= i_s_axis_tdata[SB-1:0];
            if (i_s_axis_tuser[0]) begin
                r_x1 <= '0;
                r_x2 <= '0;
                r_y1 <= '0;
                r_y2 <= '0;
            end
        end else if (r_state == ST_YUPD) begin
            r_x2 <= r_x1;
            r_x1 <= r_x;
            r_y2 <= r_y1;
            r_y1 <= w_y;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |-> !w_mul_sts.busy)
        else $error("sample accepted while the multiplier is busy");

    a_add_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> $past(w_mul_sts.done))
        else $error("accumulate without a finished product");

    a_out_after_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_term == TERM_GAIN))
        else $error("output step reached before the gain product");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire

// ----- sv/tbpi_dsmul.sv -----
// ============================================================================
// tbpi_dsmul - digit-serial signed multiplier
// Multiplies a parallel signed operand by a serial signed operand that is
// shifted in one digit per cycle, most significant digit first.
// ============================================================================
`default_nettype none

module tbpi_dsmul #(
    parameter int PAR_W   = tbpi_pkg::COEF_BITS,
    parameter int DIGIT   = tbpi_pkg::DIGIT,
    parameter int N_SHORT = 2,
    parameter int N_LONG  = 4
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  tbpi_pkg::t_mul_cmd                   i_cmd,
    input  wire  signed [PAR_W-1:0]              i_par,
    // Serial operand, aligned so that its first digit is in the top bits.
    input  wire         [N_LONG*DIGIT-1:0]       i_ser,
    output tbpi_pkg::t_mul_sts                   o_sts,
    output logic signed [PAR_W+N_LONG*DIGIT-1:0] o_prod
);

    localparam int SER_W  = N_LONG * DIGIT;
    localparam int PROD_W = PAR_W + SER_W;
    localparam int PP_W   = PAR_W + DIGIT + 1;
    localparam int CNT_W  = $clog2(N_LONG + 1);

    logic                     r_busy;
    logic                     r_done;
    logic                     r_first;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [PAR_W-1:0]  r_par;
    logic [SER_W-1:0]         r_ser;
    logic signed [PROD_W-1:0] r_prod;

    logic [DIGIT-1:0]         w_digit;
    logic signed [DIGIT:0]    w_digit_s;
    logic signed [PP_W-1:0]   w_pp;

    // Only the leading digit carries the sign; the others are plain magnitudes.
    assign w_digit   = r_ser[SER_W-1 -: DIGIT];
    assign w_digit_s = {r_first & w_digit[DIGIT-1], w_digit};
    assign w_pp      = r_par * w_digit_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= i_cmd.long_op ? CNT_W'(N_LONG) : CNT_W'(N_SHORT);
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_cnt   <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Horner form: shift the partial product up one digit and add the next term.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_par  <= i_par;
            r_ser  <= i_ser;
            r_prod <= '0;
        end else if (r_busy) begin
            r_ser  <= r_ser << DIGIT;
            r_prod <= (r_prod <<< DIGIT) + PROD_W'(w_pp);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_prod;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("multiplier started while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> r_busy)
        else $error("multiplier did not go busy after start");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done is longer than one cycle");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the two-pole band-pass IIR
// Streams signed audio samples through the filter under several coefficient
// settings and compares every output transaction against a bit-accurate
// fixed-point model of the recursion kept inside the bench.
// ============================================================================

module tb;

    import tbpi_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants.
    // ------------------------------------------------------------------------
    localparam int SW      = SAMPLE_BITS_DEF;
    localparam int TDATA_W = ((SW + 7) / 8) * 8;

    // Indexes past the last register. The filter must ignore writes to them.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic signed [SW-1:0]        SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SW-1:0]        SAMPLE_MIN = 16'sh8000;
    localparam logic [CFG_DATA_W-1:0]       COEF_MAX   = 24'h7FFFFF;
    localparam logic [CFG_DATA_W-1:0]       COEF_MIN   = 24'h800000;
    localparam logic [CFG_DATA_W-1:0]       COEF_ZERO  = 24'h000000;
    localparam logic [CFG_DATA_W-1:0]       GAIN_HALF  = 24'h000080;

    localparam int RANDOM_SETTINGS   = 6;
    localparam int ITEMS_PER_SETTING = 175;

    // The long downstream stall starts once this many results have arrived,
    // which falls in a setting where the sender never idles.
    localparam int HOLD_AT_RESULT = 800;
    localparam int HOLD_CYCLES    = 400;

    // Time given after the last sample for its result to come back.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 buffer_start;
    } t_audio_item;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that drive the filter. Every input starts
    // at a known value.
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic [TDATA_W-1:0]     s_data    = '0;
    logic [0:0]             s_user    = '0;
    logic                   m_ready   = 1'b0;
    logic                   cfg_ready;
    logic                   s_ready;
    logic                   m_valid;
    logic [TDATA_W-1:0]     m_data;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_pole_bandpass_iir i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // sample_in
        .i_s_axis_tuser  (s_user),   // buffer_start
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // sample_out
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    t_audio_item          sample_backlog[$];  // samples not yet offered
    logic signed [SW-1:0] want_samples[$];    // predicted outputs, oldest first
    t_audio_item          next_item;
    logic signed [SW-1:0] want;

    // The directed part runs in the first idling phase.
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 49;
    int unsigned results_seen  = 0;
    int unsigned fault_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_left     = 0;
    logic        hold_taken    = 1'b0;

    // Copy of the filter registers, updated as each write transaction lands.
    logic signed [COEF_BITS-1:0] coef_a0_q = COEF_A0_RST;
    logic signed [COEF_BITS-1:0] coef_a1_q = '0;
    logic signed [COEF_BITS-1:0] coef_a2_q = '0;
    logic signed [COEF_BITS-1:0] coef_b1_q = '0;
    logic signed [COEF_BITS-1:0] coef_b2_q = '0;
    logic [GAIN_BITS-1:0]        gain_q    = GAIN_RST;

    // Delay line of the model: two past inputs as plain samples and two past
    // outputs carrying 8 extra fraction bits.
    logic signed [SW-1:0]         x1_q = '0;
    logic signed [SW-1:0]         x2_q = '0;
    logic signed [STATE_BITS-1:0] y1_q = '0;
    logic signed [STATE_BITS-1:0] y2_q = '0;

    // ------------------------------------------------------------------------
    // Fixed-point model of one filter step.
    // ------------------------------------------------------------------------
    function automatic longint clamp_signed(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [SW-1:0] resonator_step(logic signed [SW-1:0] x_in,
                                                           logic clear);
        longint ff;
        longint acc;
        longint y;
        longint scaled;
        longint ff_limit;
        ff_limit = longint'(1) << FF_LIMIT_LOG2;
        // A buffer start empties the delay line before this sample is used.
        if (clear) begin
            x1_q = '0;
            x2_q = '0;
            y1_q = '0;
            y2_q = '0;
        end
        ff = longint'(coef_a0_q) * longint'(x_in)
           + longint'(coef_a1_q) * longint'(x1_q)
           + longint'(coef_a2_q) * longint'(x2_q);
        // The feed-forward sum is clamped before scaling; with 16-bit samples
        // it cannot get there, but the clamp is kept so the model stays exact.
        if (ff > ff_limit) begin
            ff = ff_limit;
        end else if (ff < -ff_limit) begin
            ff = -ff_limit;
        end
        // Bring the feed-forward part up to the feedback's binary point.
        acc = ff * (longint'(1) << STATE_FRAC)
            + longint'(coef_b1_q) * longint'(y1_q)
            + longint'(coef_b2_q) * longint'(y2_q);
        // Signed division truncates toward zero, as the filter must.
        y = clamp_signed(acc / (longint'(1) << COEF_FRAC_BITS_DEF), STATE_BITS);
        x2_q = x1_q;
        x1_q = x_in;
        y2_q = y1_q;
        y1_q = y[STATE_BITS-1:0];
        // Gain is unsigned Q8.8, so it is zero-extended into the product.
        scaled = (y * longint'(gain_q)) / (longint'(1) << OUT_SHIFT);
        scaled = clamp_signed(scaled, SW);
        return scaled[SW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver. A transaction completes at an edge where tvalid and
    // tready are both high; the expected output is predicted right there, so
    // the model sees samples in exactly the order the filter accepts them.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                want_samples.push_back(resonator_step(s_data[SW-1:0], s_user[0]));
            end
            if (!s_valid || s_ready) begin
                // The slot is free: offer the next sample unless the sender
                // decides to idle this cycle.
                if (sample_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = sample_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= TDATA_W'(next_item.sample);
                    s_user  <= next_item.buffer_start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Downstream ready. Besides the random stalls it holds off once for a long
    // stretch, counted here, so that the filter fills up and stalls its input
    // while the sender keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_taken && results_seen >= HOLD_AT_RESULT) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: each accepted output transaction is checked against the
    // oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (want_samples.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected output sample %0d", $realtime,
                             $signed(m_data[SW-1:0]));
                end
            end else begin
                want = want_samples.pop_front();
                if (m_data[SW-1:0] !== want) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("[%0t] sample_out mismatch: expected %0d, got %0d",
                                 $realtime, want, $signed(m_data[SW-1:0]));
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // One configuration transaction. The model's register copy is updated at
    // the edge where the write lands; writes only happen with the filter idle.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (index)
            REG_COEF_A0:     coef_a0_q = data;
            REG_COEF_A1:     coef_a1_q = data;
            REG_COEF_A2:     coef_a2_q = data;
            REG_COEF_B1:     coef_b1_q = data;
            REG_COEF_B2:     coef_b2_q = data;
            // Bits above the 16-bit gain are dropped.
            REG_OUTPUT_GAIN: gain_q    = data[GAIN_BITS-1:0];
            default:         ;
        endcase
    endtask

    task automatic queue_item(logic signed [SW-1:0] sample, logic buffer_start);
        t_audio_item item;
        item.sample       = sample;
        item.buffer_start = buffer_start;
        sample_backlog.push_back(item);
    endtask

    // Waits until every queued sample has been taken and every predicted
    // output has come back, so the filter is idle.
    task automatic drain();
        @(posedge clk);
        while (sample_backlog.size() != 0 || s_valid || want_samples.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Loads one coefficient set. Style 1 is raw random words, which mostly
    // drive the feedback into saturation; the others build a plausible
    // resonator (b2 = -r^2, |b1| <= 2r, a2 = -a0) so that long buffers ring
    // without blowing up. Style 2 pairs it with a large output gain.
    task automatic load_random_setting(int unsigned style);
        int pole_r;
        int a0;
        int b1;
        int b2;
        int unsigned gain;
        if (style == 1) begin
            write_reg(REG_COEF_A0, CFG_DATA_W'($urandom));
            write_reg(REG_COEF_A1, CFG_DATA_W'($urandom));
            write_reg(REG_COEF_A2, CFG_DATA_W'($urandom));
            write_reg(REG_COEF_B1, CFG_DATA_W'($urandom));
            write_reg(REG_COEF_B2, CFG_DATA_W'($urandom));
            gain = $urandom_range(0, 65535);
        end else begin
            pole_r = $urandom_range(943718, 1046528);  // r from 0.9 to 0.998
            b2 = -int'((longint'(pole_r) * longint'(pole_r)) >>> COEF_FRAC_BITS_DEF);
            b1 = int'($urandom_range(0, 4 * pole_r)) - 2 * pole_r;
            a0 = $urandom_range(1, 1 << 18);
            write_reg(REG_COEF_A0, CFG_DATA_W'(a0));
            write_reg(REG_COEF_A1, CFG_DATA_W'(int'($urandom_range(0, 2 * a0)) - a0));
            write_reg(REG_COEF_A2, CFG_DATA_W'(-a0));
            write_reg(REG_COEF_B1, CFG_DATA_W'(b1));
            write_reg(REG_COEF_B2, CFG_DATA_W'(b2));
            gain = (style == 2) ? $urandom_range(4096, 65535) : $urandom_range(16, 1024);
        end
        // Random upper bits ride along with the gain and must be ignored.
        write_reg(REG_OUTPUT_GAIN, {8'($urandom), 16'(gain)});
        if ($urandom_range(0, 1) == 1) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                      CFG_DATA_W'($urandom));
        end
    endtask

    // One buffer of random samples: mostly full-range words, some small
    // values near zero and some rail values. The buffer opens with a start
    // flag, and a few more starts fall inside it.
    task automatic queue_random_buffer(int unsigned count);
        logic signed [SW-1:0] sample;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                1, 2, 3: sample = SW'($urandom_range(0, 1023) - 512);
                default: sample = SW'($urandom);
            endcase
            queue_item(sample, (n == 0) || ($urandom_range(0, 49) == 0));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients make the filter a pass-through: rails, zero and
        // the smallest magnitudes must come back unchanged.
        queue_item(SAMPLE_MAX, 1'b1);
        queue_item(SAMPLE_MIN, 1'b0);
        queue_item(16'sd0, 1'b0);
        queue_item(-16'sd1, 1'b0);
        queue_item(16'sd1, 1'b0);
        drain();

        // Extreme feed-forward coefficients with the largest gain saturate
        // the output both ways. Writes to the unused indexes change nothing,
        // and the gain write carries set bits above the register width.
        write_reg(REG_COEF_A0, COEF_MAX);
        write_reg(REG_COEF_A1, COEF_MIN);
        write_reg(REG_COEF_A2, COEF_MAX);
        write_reg(REG_COEF_B1, COEF_ZERO);
        write_reg(REG_COEF_B2, COEF_ZERO);
        write_reg(REG_OUTPUT_GAIN, 24'hFFFFFF);
        write_reg(REG_SPARE_6, COEF_MAX);
        write_reg(REG_SPARE_7, COEF_MIN);
        queue_item(SAMPLE_MAX, 1'b1);
        queue_item(SAMPLE_MIN, 1'b0);
        queue_item(SAMPLE_MAX, 1'b0);
        queue_item(SAMPLE_MIN, 1'b0);
        drain();

        // Maximum positive and negative feedback: the stored output runs
        // into the 32-bit rails. A gain of one LSB keeps the output in range.
        write_reg(REG_COEF_A1, COEF_ZERO);
        write_reg(REG_COEF_A2, COEF_ZERO);
        write_reg(REG_COEF_B1, COEF_MAX);
        write_reg(REG_COEF_B2, COEF_MIN);
        write_reg(REG_OUTPUT_GAIN, 24'h000001);
        queue_item(SAMPLE_MAX, 1'b1);
        queue_item(SAMPLE_MAX, 1'b0);
        queue_item(SAMPLE_MAX, 1'b0);
        queue_item(SAMPLE_MIN, 1'b0);
        queue_item(SAMPLE_MIN, 1'b0);
        queue_item(SAMPLE_MIN, 1'b0);
        drain();

        // Zero gain silences everything, including right after a start.
        write_reg(REG_OUTPUT_GAIN, 24'h000000);
        queue_item(SAMPLE_MIN, 1'b0);
        queue_item(16'sd12345, 1'b1);
        drain();

        // Unity a0 with half gain: odd samples land on half an LSB and must
        // truncate toward zero, not round down.
        write_reg(REG_COEF_A0, CFG_DATA_W'(COEF_A0_RST));
        write_reg(REG_COEF_B1, COEF_ZERO);
        write_reg(REG_COEF_B2, COEF_ZERO);
        write_reg(REG_OUTPUT_GAIN, GAIN_HALF);
        queue_item(-16'sd1, 1'b1);
        queue_item(-16'sd3, 1'b0);
        queue_item(16'sd3, 1'b0);

        // Random part. The first two settings idle the sender more lightly
        // than the receiver, the next two the other way round, and the last
        // two run without idling (and contain the long downstream stall).
        for (int k = 0; k < RANDOM_SETTINGS; k++) begin
            drain();
            case (k / 2)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            load_random_setting(k % 3);
            queue_random_buffer(ITEMS_PER_SETTING);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        fault_count += want_samples.size();
        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
